>>> rtl/epc_pkg.sv
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types, register codes and the commutation table for the encoder
// position commutator.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam logic [5:0] BRIDGE_OFF   = 6'b111111;
    localparam logic [8:0] HALF_TURN    = 9'd128;
    localparam logic [7:0] OFFSET_RESET = 8'hE0;
    localparam logic [7:0] STEP_RESET   = 8'd1;

    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_INDEX = 1'b1;

    localparam logic [1:0] REG_SENSOR_OFFSET    = 2'd0;
    localparam logic [1:0] REG_STEP_INCREMENT   = 2'd1;
    localparam logic [1:0] REG_SENSOR_DETECTING = 2'd2;

    localparam logic [2:0] SECTOR_COUNT = 3'd6;

    typedef struct packed {
        logic       kind;
        logic       pin_a;
        logic       pin_b;
        logic [7:0] drive_advance;
        logic       fault;
    } item_t;

    typedef struct packed {
        logic [5:0] phase_lines;
        logic [7:0] angle_fraction;
        logic [7:0] rotation_count;
    } result_t;

    typedef struct packed {
        logic [7:0] sensor_offset;
        logic [7:0] step_increment;
        logic       sensor_detecting;
    } cfg_t;

    function automatic logic [5:0] commutation_lines(input logic [2:0] sector);
        logic [5:0] lines;
        unique case (sector)
            3'd0:    lines = 6'b101110;
            3'd1:    lines = 6'b011110;
            3'd2:    lines = 6'b011101;
            3'd3:    lines = 6'b110101;
            3'd4:    lines = 6'b110011;
            3'd5:    lines = 6'b101011;
            default: lines = BRIDGE_OFF;
        endcase
        return lines;
    endfunction

endpackage

>>> rtl/epc_cfg_regs.sv
// ----------------------------------------------------------------------------
// epc_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module epc_cfg_regs
    import epc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SENSOR_OFFSET:    cfg_next.sensor_offset    = cfg_data;
                REG_STEP_INCREMENT:   cfg_next.step_increment   = cfg_data;
                REG_SENSOR_DETECTING: cfg_next.sensor_detecting = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_offset    <= OFFSET_RESET;
            cfg_reg.step_increment   <= STEP_RESET;
            cfg_reg.sensor_detecting <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/epc_track.sv
// ----------------------------------------------------------------------------
// epc_track
// Angle and rotation tracking state with six-step commutation decode.
// ----------------------------------------------------------------------------
module epc_track
    import epc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    update,
    input  item_t   item,
    output result_t result
);

    logic [7:0]  angle_reg;
    logic [7:0]  angle_next;
    logic [7:0]  rotations_reg;
    logic [7:0]  rotations_next;
    logic [5:0]  bridge_reg;
    logic [5:0]  bridge_next;
    logic [7:0]  angle_plus;
    logic [7:0]  angle_minus;
    logic [7:0]  step_angle;
    logic [7:0]  position;
    logic [10:0] scaled;
    logic [2:0]  sector;
    logic        index_up;
    logic        index_down;

    assign angle_plus  = angle_reg + cfg.step_increment;
    assign angle_minus = angle_reg - cfg.step_increment;
    assign step_angle  = (item.pin_a != item.pin_b) ? angle_plus : angle_minus;
    assign position    = step_angle + item.drive_advance;
    assign scaled      = ({3'b000, position} << 2) + ({3'b000, position} << 1) + 11'd128;
    assign sector      = (scaled[10:8] == SECTOR_COUNT) ? 3'd0 : scaled[10:8];
    assign index_up    = {1'b0, angle_reg} > (HALF_TURN + {1'b0, cfg.sensor_offset});
    assign index_down  = ({1'b0, angle_reg} + HALF_TURN) < {1'b0, cfg.sensor_offset};

    always_comb
    begin
        angle_next     = angle_reg;
        rotations_next = rotations_reg;
        bridge_next    = bridge_reg;
        if (item.kind == KIND_STEP)
        begin
            if (item.pin_a != item.pin_b)
            begin
                angle_next = angle_plus;
                if (angle_plus == 8'd0)
                begin
                    rotations_next = rotations_reg + 8'd1;
                end
            end
            else
            begin
                angle_next = angle_minus;
                if (angle_reg == 8'd0)
                begin
                    rotations_next = rotations_reg - 8'd1;
                end
            end
            if (!cfg.sensor_detecting)
            begin
                if (item.fault || item.drive_advance == 8'd0)
                begin
                    bridge_next = BRIDGE_OFF;
                end
                else
                begin
                    bridge_next = commutation_lines(sector);
                end
            end
        end
        else
        begin
            if (index_up)
            begin
                rotations_next = rotations_reg + 8'd1;
            end
            else if (index_down)
            begin
                rotations_next = rotations_reg - 8'd1;
            end
            angle_next = cfg.sensor_offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg     <= 8'd0;
            rotations_reg <= 8'd0;
            bridge_reg    <= BRIDGE_OFF;
        end
        else if (update)
        begin
            angle_reg     <= angle_next;
            rotations_reg <= rotations_next;
            bridge_reg    <= bridge_next;
        end
    end

    assign result.phase_lines    = bridge_next;
    assign result.angle_fraction = angle_next;
    assign result.rotation_count = rotations_next;

    // index event resyncs the angle and leaves the bridge alone
    assert property (@(posedge clk) disable iff (!rst_n)
        update && item.kind == KIND_INDEX |=>
            angle_reg == $past(cfg.sensor_offset) && bridge_reg == $past(bridge_reg))
        else $error("index event did not resync angle or changed bridge");

    assert property (@(posedge clk) disable iff (!rst_n)
        update && item.kind == KIND_STEP && !cfg.sensor_detecting &&
        (item.fault || item.drive_advance == 8'd0) |=> bridge_reg == BRIDGE_OFF)
        else $error("bridge not off after fault or zero drive");

    assert property (@(posedge clk) disable iff (!rst_n)
        update && item.kind == KIND_STEP && cfg.sensor_detecting |=> $stable(bridge_reg))
        else $error("bridge changed during sensor detection");

    assert property (@(posedge clk) disable iff (!rst_n)
        !update |=> $stable(angle_reg) && $stable(rotations_reg))
        else $error("tracking state moved without a transaction");

endmodule

>>> rtl/encoder_position_commutator_core.sv
// ----------------------------------------------------------------------------
// encoder_position_commutator_core
// Quadrature encoder position tracker with six-step bridge commutation.
// ----------------------------------------------------------------------------
// an accepted transaction passes through the input register, then the result register
// throughput: one transaction per cycle while the result is not stalled, with the
//   state update between the input register and the result register
// reset: angle and rotation count zero, bridge lines all off, offset 0xE0,
//   step increment 1, sensor detection off
module encoder_position_commutator_core
    import epc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic       pin_a,
    input  logic       pin_b,
    input  logic [7:0] drive_advance,
    input  logic       fault,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [5:0] phase_lines,
    output logic [7:0] angle_fraction,
    output logic [7:0] rotation_count
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    logic    item_valid_next;
    result_t track_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_free;
    logic    item_move;
    logic    in_take;

    epc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    epc_track u_track
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .update (item_move),
        .item   (item_reg),
        .result (track_result)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign item_move = item_valid_reg && out_free;
    assign in_stall  = item_valid_reg && !item_move;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = in_take ? 1'b1 : (item_move ? 1'b0 : item_valid_reg);
        out_valid_next  = item_move ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.kind          <= kind;
            item_reg.pin_a         <= pin_a;
            item_reg.pin_b         <= pin_b;
            item_reg.drive_advance <= drive_advance;
            item_reg.fault         <= fault;
        end
        if (item_move)
        begin
            result_reg <= track_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign phase_lines    = result_reg.phase_lines;
    assign angle_fraction = result_reg.angle_fraction;
    assign rotation_count = result_reg.rotation_count;

    // held input transaction always moves on once the result slot frees
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && out_free |=> out_valid_reg)
        else $error("held transaction did not reach the result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(result_reg))
        else $error("stalled result lost or changed");

endmodule

>>> tb/epc_checker.sv
// ----------------------------------------------------------------------------
// epc_checker
// Watches the configuration port and both channels of the encoder position
// commutator. It keeps its own copy of the angle, rotation count, bridge lines
// and registers, predicts the result of every accepted input transaction and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module epc_checker
    import epc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       kind,
    input  logic       pin_a,
    input  logic       pin_b,
    input  logic [7:0] drive_advance,
    input  logic       fault,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [5:0] phase_lines,
    input  logic [7:0] angle_fraction,
    input  logic [7:0] rotation_count,
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t       cfg;
    logic [7:0] angle;
    logic [7:0] rotations;
    logic [5:0] bridge_lines;
    result_t    expected_results[$];

    function automatic logic [5:0] commutation_pattern(input logic [7:0] position,
                                                       input logic [7:0] advance);
        logic [7:0]  lead;
        logic [10:0] scaled;
        logic [2:0]  sector;
        logic [5:0]  lines;
        lead   = position + advance;
        scaled = lead * 11'd6 + 11'd128;
        sector = scaled[10:8];
        if (sector >= SECTOR_COUNT)
            sector = 3'd0;
        case (sector)
            3'd0:    lines = 6'b101110;
            3'd1:    lines = 6'b011110;
            3'd2:    lines = 6'b011101;
            3'd3:    lines = 6'b110101;
            3'd4:    lines = 6'b110011;
            default: lines = 6'b101011;
        endcase
        return lines;
    endfunction

    function automatic result_t track_transaction(input item_t it);
        result_t res;
        if (it.kind == KIND_STEP) begin
            if (it.pin_a != it.pin_b) begin
                angle = angle + cfg.step_increment;
                if (angle == 8'd0)
                    rotations = rotations + 8'd1;
            end
            else begin
                if (angle == 8'd0)
                    rotations = rotations - 8'd1;
                angle = angle - cfg.step_increment;
            end
            if (!cfg.sensor_detecting) begin
                if (it.fault || it.drive_advance == 8'd0)
                    bridge_lines = BRIDGE_OFF;
                else
                    bridge_lines = commutation_pattern(angle, it.drive_advance);
            end
        end
        else begin
            // index resync, rotation count corrected with unwrapped sums
            if (int'(angle) > int'(HALF_TURN) + int'(cfg.sensor_offset))
                rotations = rotations + 8'd1;
            else if (int'(angle) + int'(HALF_TURN) < int'(cfg.sensor_offset))
                rotations = rotations - 8'd1;
            angle = cfg.sensor_offset;
        end
        res.phase_lines    = bridge_lines;
        res.angle_fraction = angle;
        res.rotation_count = rotations;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        item_t   it;
        if (!rst_n) begin
            cfg.sensor_offset    = OFFSET_RESET;
            cfg.step_increment   = STEP_RESET;
            cfg.sensor_detecting = 1'b0;
            angle                = 8'd0;
            rotations            = 8'd0;
            bridge_lines         = BRIDGE_OFF;
            expected_results.delete();
            mismatches           = 0;
            outstanding          = 0;
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == REG_SENSOR_OFFSET)
                    cfg.sensor_offset = cfg_data;
                else if (cfg_index == REG_STEP_INCREMENT)
                    cfg.step_increment = cfg_data;
                else if (cfg_index == REG_SENSOR_DETECTING)
                    cfg.sensor_detecting = cfg_data[0];
            end
            if (out_valid && !out_stall) begin
                got.phase_lines    = phase_lines;
                got.angle_fraction = angle_fraction;
                got.rotation_count = rotation_count;
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result lines %h angle %h count %h",
                                 $realtime, got.phase_lines, got.angle_fraction,
                                 got.rotation_count);
                    mismatches = mismatches + 1;
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.phase_lines != want.phase_lines
                        || got.angle_fraction != want.angle_fraction
                        || got.rotation_count != want.rotation_count) begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch expected lines %h angle %h count %h,",
                                      " got lines %h angle %h count %h"},
                                     $realtime, want.phase_lines, want.angle_fraction,
                                     want.rotation_count, got.phase_lines,
                                     got.angle_fraction, got.rotation_count);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                it.kind          = kind;
                it.pin_a         = pin_a;
                it.pin_b         = pin_b;
                it.drive_advance = drive_advance;
                it.fault         = fault;
                expected_results.push_back(track_transaction(it));
            end
            outstanding = expected_results.size();
        end
    end

endmodule

>>> tb/tb_encoder_position_commutator_core.sv
// ----------------------------------------------------------------------------
// tb_encoder_position_commutator_core
// Drives encoder steps and home-index events into the commutator core under
// several register settings, idle and stall patterns. A short directed sequence
// covers wraps, index corrections, sensor detection and odd increments, then
// random bursts of steps run in both directions. Results are checked by
// epc_checker.
// ----------------------------------------------------------------------------
module tb_encoder_position_commutator_core
    import epc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       kind;
    logic       pin_a;
    logic       pin_b;
    logic [7:0] drive_advance;
    logic       fault;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [5:0] phase_lines;
    logic [7:0] angle_fraction;
    logic [7:0] rotation_count;
    int         mismatches;
    int         outstanding;
    int         idle_pct  = 0;
    int         stall_pct = 0;

    encoder_position_commutator_core DUT (.*);

    epc_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_item(input logic k, input logic a, input logic b,
                             input logic [7:0] drv, input logic f);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        pin_a         <= a;
        pin_b         <= b;
        drive_advance <= drv;
        fault         <= f;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] offset_sel, input logic [7:0] increment_sel,
                             input logic detect_sel);
        drain();
        write_reg(REG_SENSOR_OFFSET, offset_sel);
        write_reg(REG_STEP_INCREMENT, increment_sel);
        write_reg(REG_SENSOR_DETECTING, {7'd0, detect_sel});
        write_reg(REG_UNUSED, 8'($urandom_range(255)));
    endtask

    task automatic random_items(input int count);
        logic       forward;
        logic       a;
        int         roll;
        logic [7:0] drv;
        forward = 1'b1;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 12)
                drv = 8'd0;
            else if (roll < 20)
                drv = 8'hFF;
            else
                drv = 8'($urandom_range(255));
            if ($urandom_range(99) < 10) begin
                send_item(KIND_INDEX, 1'($urandom_range(1)), 1'($urandom_range(1)), drv,
                          1'($urandom_range(1)));
            end
            else begin
                // direction runs in bursts so the rotation count wraps both ways
                if ($urandom_range(99) < 15)
                    forward = ~forward;
                a = 1'($urandom_range(1));
                send_item(KIND_STEP, a, forward ? ~a : a, drv, $urandom_range(99) < 8);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] offset_sel;
        logic [7:0] increment_sel;
        logic       detect_sel;
        rst_n         = 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_SENSOR_OFFSET;
        cfg_data      <= 8'd0;
        in_valid      <= 1'b0;
        kind          <= KIND_STEP;
        pin_a         <= 1'b0;
        pin_b         <= 1'b0;
        drive_advance <= 8'd0;
        fault         <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: index below the offset window, all pin pairs
        send_item(KIND_INDEX, 1'b0, 1'b0, 8'd0, 1'b0);
        send_item(KIND_STEP, 1'b1, 1'b0, 8'd0, 1'b0);
        send_item(KIND_STEP, 1'b0, 1'b1, 8'hFF, 1'b0);
        send_item(KIND_STEP, 1'b1, 1'b1, 8'h80, 1'b1);
        send_item(KIND_STEP, 1'b0, 1'b0, 8'h01, 1'b0);

        // half-turn steps: wrap up and down through zero
        configure(8'd128, 8'd128, 1'b0);
        send_item(KIND_INDEX, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_item(KIND_STEP, 1'b1, 1'b0, 8'h40, 1'b0);
        send_item(KIND_STEP, 1'b0, 1'b0, 8'hC0, 1'b0);
        send_item(KIND_STEP, 1'b1, 1'b1, 8'h2A, 1'b0);
        send_item(KIND_STEP, 1'b0, 1'b0, 8'hFF, 1'b0);

        // increment above a half turn, index inside the offset window
        configure(8'd0, 8'd129, 1'b0);
        send_item(KIND_INDEX, 1'b0, 1'b1, 8'h00, 1'b0);
        send_item(KIND_STEP, 1'b0, 1'b1, 8'h55, 1'b0);
        send_item(KIND_INDEX, 1'b1, 1'b0, 8'h01, 1'b1);
        send_item(KIND_STEP, 1'b1, 1'b1, 8'hAA, 1'b1);

        // sensor detection holds the bridge lines
        configure(8'd255, 8'd0, 1'b1);
        send_item(KIND_INDEX, 1'b0, 1'b0, 8'h7F, 1'b0);
        send_item(KIND_STEP, 1'b1, 1'b0, 8'h10, 1'b0);
        send_item(KIND_STEP, 1'b0, 1'b0, 8'h00, 1'b1);
        configure(8'd255, 8'd1, 1'b1);
        send_item(KIND_STEP, 1'b0, 1'b1, 8'h33, 1'b0);

        // zero increment still counts rotations at angle zero
        configure(8'd0, 8'd0, 1'b0);
        send_item(KIND_STEP, 1'b1, 1'b0, 8'hF0, 1'b0);
        send_item(KIND_STEP, 1'b1, 1'b1, 8'h0F, 1'b0);
        send_item(KIND_STEP, 1'b0, 1'b1, 8'd0, 1'b1);

        for (int p = 0; p < 8; p++) begin
            offset_sel    = 8'($urandom_range(255));
            increment_sel = 8'($urandom_range(1, 128));
            detect_sel    = $urandom_range(99) < 25;
            case (p)
                0: begin
                    offset_sel    = 8'd0;
                    increment_sel = 8'd1;
                    detect_sel    = 1'b0;
                end
                1: begin
                    offset_sel    = 8'd255;
                    increment_sel = 8'd128;
                    detect_sel    = 1'b0;
                end
                2: begin
                    increment_sel = 8'd0;
                    detect_sel    = 1'b0;
                end
                3: increment_sel = 8'($urandom_range(129, 255));
                default: ;
            endcase
            configure(offset_sel, increment_sel, detect_sel);
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 87;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 87;
                end
                default: begin
                    idle_pct  = 13;
                    stall_pct = 13;
                end
            endcase
            random_items(125);
        end

        drain();
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
